// File: rtl/core/itrd_pkg.sv
`default_nettype none

package itrd_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int MAX_RADIX   = 16;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int STEP_BITS   = 4;
    localparam int DIV_CYCLES  = VALUE_BITS / STEP_BITS;
    localparam int DIV_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int MAX_DIGITS  = VALUE_BITS;
    localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int STACK_W     = MAX_DIGITS * DIGIT_W;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 7;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RADIX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(MAX_RADIX);
    localparam logic [CFG_W-1:0]   CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]   CHARS_HIGH_RESET = 64'h6665_6463_6261_3938;

    function automatic logic [CHAR_W-1:0] char_lookup(
        input logic [CFG_W-1:0]   chars_low,
        input logic [CFG_W-1:0]   chars_high,
        input logic [DIGIT_W-1:0] digit
    );
        logic [CFG_W-1:0] row;
        row = digit[DIGIT_W-1] ? chars_high : chars_low;
        return row[digit[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/integer_to_radix_digits_core.sv
// integer to radix digits
// input channel (i_in_valid / o_in_ready) takes a 64-bit value and a signed flag;
// output channel (o_out_valid / i_out_ready) gives one beat per digit, most
// significant first, with the digit character, a minus mark on the first beat
// of a negative value, the total printed length and a last flag.
// the config port (i_cfg_we, i_cfg_index, i_cfg_data) sets the base and the
// two halves of the character table; write it only while the core is idle.
// the core works on one value at a time: o_in_ready is high only when idle.
// each digit is one long division of the magnitude by the base, done by a
// 4-bit-per-cycle shift divider; a value's digits are all computed first,
// then sent as output beats, one per digit and one per cycle while the
// receiver is ready (at most 64 digits, as for a 64-digit base-2 value).
// digits are held on a shift-register stack and popped msd first.
// a stalled receiver simply holds the current beat; nothing is lost.
// synchronous active-low reset returns the core to idle, drops any value in
// flight and restores base 10 and the table "0123456789abcdef".
`default_nettype none

module integer_to_radix_digits_core
    import itrd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [63:0]          i_value,
    input  wire logic                 i_signed_mode,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [CHAR_W-1:0]         o_digit_char,
    output logic                      o_minus_before,
    output logic [LEN_W-1:0]          o_total_length,
    output logic                      o_last_digit
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [RADIX_W-1:0]    r_base;
    logic [CFG_W-1:0]      r_chars_low;
    logic [CFG_W-1:0]      r_chars_high;

    logic [1:0]            r_state,   n_state;
    logic [VALUE_BITS-1:0] r_mag,     n_mag;
    logic [RADIX_W-1:0]    r_radix,   n_radix;
    logic [RADIX_W-1:0]    r_rem,     n_rem;
    logic                  r_qnz,     n_qnz;
    logic [DIV_CNT_W-1:0]  r_cyc,     n_cyc;
    logic [STACK_W-1:0]    r_stack,   n_stack;
    logic [COUNT_W-1:0]    r_count,   n_count;
    logic [COUNT_W-1:0]    r_left,    n_left;
    logic                  r_neg,     n_neg;
    logic                  r_first,   n_first;

    logic [VALUE_BITS-1:0] in_v;
    logic                  in_neg;
    logic [RADIX_W-1:0]    radix_clamped;
    logic [STEP_BITS-1:0]  step_q;
    logic [RADIX_W-1:0]    step_rem;
    logic                  in_acc;
    logic                  out_acc;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= RADIX_RESET;
            r_chars_low  <= CHARS_LOW_RESET;
            r_chars_high <= CHARS_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_RADIX: r_base       <= i_cfg_data[RADIX_W-1:0];
                CFG_CHARS_LOW:  r_chars_low  <= i_cfg_data;
                CFG_CHARS_HIGH: r_chars_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_v   = i_value[VALUE_BITS-1:0];
    assign in_neg = i_signed_mode && in_v[VALUE_BITS-1];

    always_comb begin
        priority if (r_base < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (r_base > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = r_base;
        end
    end

    // one divider step: STEP_BITS restoring subtracts on a narrow remainder
    always_comb begin
        logic [RADIX_W:0] t;
        logic [RADIX_W-1:0] rem;
        rem    = r_rem;
        step_q = '0;
        for (int j = STEP_BITS - 1; j >= 0; j--) begin
            t = {rem, r_mag[VALUE_BITS - STEP_BITS + j]};
            if (t >= {1'b0, r_radix}) begin
                t         = t - {1'b0, r_radix};
                step_q[j] = 1'b1;
            end
            rem = t[RADIX_W-1:0];
        end
        step_rem = rem;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_radix = r_radix;
        n_rem   = r_rem;
        n_qnz   = r_qnz;
        n_cyc   = r_cyc;
        n_stack = r_stack;
        n_count = r_count;
        n_left  = r_left;
        n_neg   = r_neg;
        n_first = r_first;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mag   = in_neg ? (~in_v + VALUE_BITS'(1)) : in_v;
                    n_neg   = in_neg;
                    n_radix = radix_clamped;
                    n_rem   = '0;
                    n_qnz   = 1'b0;
                    n_cyc   = '0;
                    n_count = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_mag = {r_mag[VALUE_BITS-STEP_BITS-1:0], step_q};
                n_rem = step_rem;
                n_qnz = r_qnz || (|step_q);
                n_cyc = r_cyc + DIV_CNT_W'(1);
                if (r_cyc == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    // digit done: push it, quotient becomes the next dividend
                    n_stack = {r_stack[STACK_W-DIGIT_W-1:0], step_rem[DIGIT_W-1:0]};
                    n_count = r_count + COUNT_W'(1);
                    n_rem   = '0;
                    n_qnz   = 1'b0;
                    n_cyc   = '0;
                    if (!(r_qnz || (|step_q))
                            || (r_count == COUNT_W'(MAX_DIGITS - 1))) begin
                        n_left  = r_count + COUNT_W'(1);
                        n_first = 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    n_stack = {{DIGIT_W{1'b0}}, r_stack[STACK_W-1:DIGIT_W]};
                    n_left  = r_left - COUNT_W'(1);
                    n_first = 1'b0;
                    if (r_left == COUNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cyc   <= '0;
            r_count <= '0;
            r_left  <= '0;
            r_first <= 1'b0;
            r_qnz   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cyc   <= n_cyc;
            r_count <= n_count;
            r_left  <= n_left;
            r_first <= n_first;
            r_qnz   <= n_qnz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_radix <= n_radix;
        r_rem   <= n_rem;
        r_stack <= n_stack;
        r_neg   <= n_neg;
    end

    // top of the stack is the most significant digit not yet sent
    assign o_digit_char   = char_lookup(r_chars_low, r_chars_high, r_stack[DIGIT_W-1:0]);
    assign o_minus_before = r_neg && r_first;
    assign o_total_length = LEN_W'(r_count) + LEN_W'(r_neg);
    assign o_last_digit   = (r_left == COUNT_W'(1));

`ifndef NO_ASSERTIONS
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_radix))
        else $error("divider remainder not below radix");

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((r_left != '0) && (r_left <= r_count)))
        else $error("emitting with no digits left");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_digit) |=> (o_in_ready && !o_out_valid))
        else $error("core not idle after last beat");

    a_minus_first_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_minus_before) |-> (r_left == r_count))
        else $error("minus mark away from first beat");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

import itrd_pkg::*;

typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              minus;
    logic [LEN_W-1:0]  len;
    logic              last;
} t_digit_beat;

class t_digit_scoreboard;
    logic [RADIX_W-1:0] base;
    logic [CFG_W-1:0]   chars_low;
    logic [CFG_W-1:0]   chars_high;
    t_digit_beat        pending_digits[$];
    int                 errors;
    int                 beats_checked;

    function new();
        base          = RADIX_RESET;
        chars_low     = CHARS_LOW_RESET;
        chars_high    = CHARS_HIGH_RESET;
        errors        = 0;
        beats_checked = 0;
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_BASE_RADIX: base = data[RADIX_W-1:0];
            CFG_CHARS_LOW:  chars_low = data;
            CFG_CHARS_HIGH: chars_high = data;
            default: ;
        endcase
    endfunction

    function logic [CHAR_W-1:0] char_at(logic [3:0] d);
        logic [2*CFG_W-1:0] tbl;
        tbl = {chars_high, chars_low};
        return tbl[int'(d) * CHAR_W +: CHAR_W];
    endfunction

    // long division by the clamped base, digits stored lsd first
    function void predict_digits(logic [63:0] raw, logic is_signed);
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        logic [63:0] radix;
        logic        neg;
        logic [3:0]  digs[64];
        int          n;
        t_digit_beat b;
        mask = ~64'd0 >> (64 - VALUE_BITS);
        v = raw & mask;
        neg = is_signed && v[VALUE_BITS-1];
        mag = neg ? ((~v + 64'd1) & mask) : v;
        if (base < RADIX_MIN)
            radix = 64'(RADIX_MIN);
        else if (base > RADIX_MAX)
            radix = 64'(RADIX_MAX);
        else
            radix = 64'(base);
        n = 0;
        do begin
            digs[n] = 4'(mag % radix);
            mag = mag / radix;
            n = n + 1;
        end while (mag != 64'd0 && n < MAX_DIGITS);
        for (int k = 0; k < n; k++) begin
            b.ch    = char_at(digs[n-1-k]);
            b.minus = (k == 0) && neg;
            b.len   = LEN_W'(n + (neg ? 1 : 0));
            b.last  = (k == n - 1);
            pending_digits.push_back(b);
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s", msg);
    endtask

    task check_beat(logic [CHAR_W-1:0] ch, logic minus, logic [LEN_W-1:0] len, logic last);
        t_digit_beat e;
        if (pending_digits.size() == 0) begin
            report($sformatf("beat with nothing expected: char %02h len %0d", ch, len));
            return;
        end
        e = pending_digits.pop_front();
        beats_checked++;
        if (ch !== e.ch)
            report($sformatf("digit char %02h, expected %02h", ch, e.ch));
        if (minus !== e.minus)
            report($sformatf("minus mark %b, expected %b", minus, e.minus));
        if (len !== e.len)
            report($sformatf("total length %0d, expected %0d", len, e.len));
        if (last !== e.last)
            report($sformatf("last flag %b, expected %b", last, e.last));
    endtask

    task close();
        if (pending_digits.size() != 0)
            report($sformatf("%0d digit beats never arrived", pending_digits.size()));
    endtask
endclass

module testbench;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 8000;
    localparam int TAIL_CYCLES = 100;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [63:0]          i_value;
    logic                 i_signed_mode;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [CHAR_W-1:0]    o_digit_char;
    logic                 o_minus_before;
    logic [LEN_W-1:0]     o_total_length;
    logic                 o_last_digit;

    t_digit_scoreboard sb;
    int sender_idle;
    int receiver_idle;
    int quiet_cycles;
    int items;
    int negatives;
    int settings;

    integer_to_radix_digits_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .i_signed_mode  (i_signed_mode),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_digit_char   (o_digit_char),
        .o_minus_before (o_minus_before),
        .o_total_length (o_total_length),
        .o_last_digit   (o_last_digit)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver side: check each digit beat, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_beat(o_digit_char, o_minus_before, o_total_length, o_last_digit);
        i_out_ready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_value(input logic [63:0] v, input logic s);
        while ($urandom_range(0, 99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_value       <= v;
        i_signed_mode <= s;
        do @(posedge i_clk); while (!o_in_ready);
        sb.predict_digits(v, s);
        items++;
        if (s && v[VALUE_BITS-1])
            negatives++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_digits.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.apply_config(idx, data);
    endtask

    task automatic load_config(input logic [RADIX_W-1:0] base, input logic [CFG_W-1:0] lo,
                               input logic [CFG_W-1:0] hi, input logic junk);
        drain();
        write_reg(CFG_BASE_RADIX, CFG_W'(base) | ({$urandom, $urandom} << RADIX_W));
        write_reg(CFG_CHARS_LOW, lo);
        write_reg(CFG_CHARS_HIGH, hi);
        if (junk)
            write_reg(CFG_UNUSED, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] full;
        int          w;
        full = {$urandom, $urandom};
        w = $urandom_range(1, 64);
        case ($urandom_range(0, 9))
            0, 1, 2: return full;
            3, 4, 5: return full >> (64 - w);
            6:       return 64'($urandom_range(0, 40));
            7:       return -(full >> (64 - w));
            default: begin
                case ($urandom_range(0, 4))
                    0: return 64'd0;
                    1: return ~64'd0;
                    2: return 64'h8000_0000_0000_0000;
                    3: return 64'h7fff_ffff_ffff_ffff;
                    default: return 64'd1;
                endcase
            end
        endcase
    endfunction

    task automatic random_config();
        logic [RADIX_W-1:0] base;
        logic [CFG_W-1:0]   lo;
        logic [CFG_W-1:0]   hi;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 5))
                    0: base = 5'd0;
                    1: base = 5'd1;
                    2: base = 5'd2;
                    3: base = 5'd16;
                    4: base = 5'd17;
                    default: base = 5'd31;
                endcase
            end
            1: base = RADIX_W'($urandom_range(17, 31));
            default: base = RADIX_W'($urandom_range(3, 16));
        endcase
        lo = $urandom_range(0, 1) ? CHARS_LOW_RESET : {$urandom, $urandom};
        hi = $urandom_range(0, 1) ? CHARS_HIGH_RESET : {$urandom, $urandom};
        load_config(base, lo, hi, $urandom_range(0, 2) == 0);
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_value       <= '0;
        i_signed_mode <= 1'b0;
        i_out_ready   <= 1'b0;
        sender_idle   = 38;
        receiver_idle = 74;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: base 10, default table
        send_value(64'd0, 1'b0);
        send_value(64'd0, 1'b1);
        send_value(~64'd0, 1'b0);
        send_value(~64'd0, 1'b1);
        send_value(64'h8000_0000_0000_0000, 1'b1);
        send_value(64'h8000_0000_0000_0000, 1'b0);
        send_value(64'h7fff_ffff_ffff_ffff, 1'b1);
        send_value(64'd9, 1'b0);
        send_value(64'd10, 1'b0);
        send_value(64'd1, 1'b1);

        load_config(5'd16, CHARS_LOW_RESET, CHARS_HIGH_RESET, 1'b0);
        send_value(~64'd0, 1'b0);
        send_value(64'h8000_0000_0000_0000, 1'b1);
        send_value(64'hfedc_ba98_7654_3210, 1'b0);

        // longest runs: 64 digits, with and without a minus
        load_config(5'd2, CHARS_LOW_RESET, CHARS_HIGH_RESET, 1'b0);
        send_value(~64'd0, 1'b0);
        send_value(64'h8000_0000_0000_0000, 1'b1);
        send_value(-64'd5, 1'b1);

        // out-of-range bases clamp
        load_config(5'd0, CHARS_LOW_RESET, CHARS_HIGH_RESET, 1'b0);
        send_value(64'd6, 1'b0);
        load_config(5'd1, CHARS_LOW_RESET, CHARS_HIGH_RESET, 1'b0);
        send_value(-64'd7, 1'b1);
        load_config(5'd17, CHARS_LOW_RESET, CHARS_HIGH_RESET, 1'b0);
        send_value(~64'd0, 1'b0);
        load_config(5'd31, CHARS_LOW_RESET, CHARS_HIGH_RESET, 1'b0);
        send_value(64'd255, 1'b0);

        // table extremes, unused index written too
        load_config(5'd16, 64'd0, ~64'd0, 1'b1);
        send_value(64'h0123_4567_89ab_cdef, 1'b0);
        send_value(~64'd0, 1'b1);
        load_config(5'd7, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        send_value(pick_value(), 1'b1);
        send_value(pick_value(), 1'b0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle   = 38;
                    receiver_idle = 74;
                end
                1: begin
                    sender_idle   = 74;
                    receiver_idle = 38;
                end
                default: begin
                    sender_idle   = 0;
                    receiver_idle = 0;
                end
            endcase
            for (int chunk = 0; chunk < 5; chunk++) begin
                random_config();
                for (int n = 0; n < 30; n++)
                    send_value(pick_value(), 1'($urandom_range(0, 1)));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.close();
        $display("converted %0d values (%0d negative) under %0d register settings",
                 items, negatives, settings);
        $display("checked %0d digit beats, %0d mismatches", sb.beats_checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
